// ===== hdl/fcpwm_pkg.sv =====
`default_nettype none

package fcpwm_pkg;

    localparam int FREQ_W = 26;
    localparam int DUTY_W = 8;
    localparam int TOP_W  = 8;
    localparam int SEL_W  = 3;
    localparam int PCNT_W = 10;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_SET     = 3'd1,
        OP_ENABLE  = 3'd2,
        OP_DISABLE = 3'd3,
        OP_READ    = 3'd4
    } opcode_t;

    // status of the frequency solver towards the top level
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [SEL_W-1:0] sel;
        logic [TOP_W-1:0] top;
    } freq_status_t;

    // prescaler ratios 1, 2, 4, 8, 16, 64, 256, 1024 as shift amounts
    function automatic logic [3:0] prescale_shift(input logic [SEL_W-1:0] sel);
        logic [3:0] sh;
        case (sel)
            3'd0:    sh = 4'd0;
            3'd1:    sh = 4'd1;
            3'd2:    sh = 4'd2;
            3'd3:    sh = 4'd3;
            3'd4:    sh = 4'd4;
            3'd5:    sh = 4'd6;
            3'd6:    sh = 4'd8;
            default: sh = 4'd10;
        endcase
        return sh;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/fcpwm_freq_solver.sv =====
`default_nettype none

module fcpwm_freq_solver #(
    parameter int CLOCK_HZ = 48000000
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [fcpwm_pkg::FREQ_W-1:0]  freq,
    output fcpwm_pkg::freq_status_t            status
);

    localparam int CLK_W  = $clog2(CLOCK_HZ + 1);
    localparam int WIDE_W = fcpwm_pkg::FREQ_W + 10;
    localparam logic [CLK_W-1:0] CLK_VAL = CLK_W'(CLOCK_HZ);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_DIVIDE = 3'b100
    } solver_state_t;

    solver_state_t                   state_reg, state_next;
    logic [fcpwm_pkg::FREQ_W-1:0]    f_reg;
    logic [fcpwm_pkg::SEL_W-1:0]     sel_reg;
    logic [fcpwm_pkg::FREQ_W-1:0]    rem_reg;
    logic [8:0]                      nlow_reg;
    logic [7:0]                      q_reg;
    logic [3:0]                      bit_reg;
    logic                            done_reg;
    logic [fcpwm_pkg::TOP_W-1:0]     top_reg;

    logic [CLK_W-1:0]                n_cand;
    logic [WIDE_W-1:0]               f_x257;
    logic                            fits;
    logic [fcpwm_pkg::FREQ_W:0]      trial;
    logic                            q_bit;
    logic [8:0]                      q_final;

    // candidate period numerator and fit test: (clk >> k) / f <= 256
    assign n_cand = CLK_VAL >> fcpwm_pkg::prescale_shift(sel_reg);
    assign f_x257 = WIDE_W'({f_reg, 8'd0}) + WIDE_W'(f_reg);
    assign fits   = WIDE_W'(n_cand) < f_x257;

    assign trial   = {rem_reg, nlow_reg[8]};
    assign q_bit   = trial >= {1'b0, f_reg};
    assign q_final = {q_reg, q_bit};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (start) state_next = S_SEARCH;
            end
            S_SEARCH: begin
                if (start) state_next = S_SEARCH;
                else if (fits) state_next = S_DIVIDE;
                else if (sel_reg == fcpwm_pkg::SEL_W'(7)) state_next = S_IDLE;
            end
            S_DIVIDE: begin
                if (start) state_next = S_SEARCH;
                else if (bit_reg == 4'd0) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            if (start) begin
                f_reg   <= (freq == '0) ? fcpwm_pkg::FREQ_W'(1) : freq;
                sel_reg <= '0;
            end else if (state_reg == S_SEARCH) begin
                if (fits) begin
                    rem_reg  <= fcpwm_pkg::FREQ_W'(n_cand >> 9);
                    nlow_reg <= n_cand[8:0];
                    q_reg    <= '0;
                    bit_reg  <= 4'd8;
                end else if (sel_reg == fcpwm_pkg::SEL_W'(7)) begin
                    // nothing fits: slowest prescaler, full range
                    top_reg  <= '1;
                    done_reg <= 1'b1;
                end else begin
                    sel_reg <= sel_reg + 1'b1;
                end
            end else if (state_reg == S_DIVIDE) begin
                rem_reg  <= q_bit ? fcpwm_pkg::FREQ_W'(trial - {1'b0, f_reg})
                                  : trial[fcpwm_pkg::FREQ_W-1:0];
                nlow_reg <= {nlow_reg[7:0], 1'b0};
                q_reg    <= q_final[7:0];
                bit_reg  <= bit_reg - 1'b1;
                if (bit_reg == 4'd0) begin
                    // period floor of 1
                    top_reg  <= (q_final < 9'd2) ? fcpwm_pkg::TOP_W'(1)
                                                 : fcpwm_pkg::TOP_W'(q_final - 9'd1);
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign status.busy = (state_reg != S_IDLE);
    assign status.done = done_reg;
    assign status.sel  = sel_reg;
    assign status.top  = top_reg;

endmodule

`default_nettype wire

// ===== hdl/four_channel_pwm_timer_unit.sv =====
// four-channel pwm timer on a prescaled 8-bit counter
// input channel (s_valid/s_ready): one command per transfer - tick, set duty,
// enable, disable or read duty - addressed by s_channel, duty in s_duty
// result channel (m_valid/m_ready): one result per command with the channel
// levels, the read-back duty and an accepted flag
// the input register loads at the transfer edge, the result register loads
// from it once empty or once its result is taken; throughput is one command
// per cycle while m_ready stays high and no frequency update is running
// a stalled receiver fills the result register and then the input register,
// after which s_ready falls until the result is taken
// cfg_wr_en/cfg_wr_data set the target frequency; the write restarts the
// counter, clears every compare value and runs the frequency solver: a
// prescaler search, a bit-serial period division, a load of the new period
// and a rebuild of the compare values one channel at a time, with s_ready
// held low from after the write until the rebuild ends
// reset loads the values for 1000 Hz (divide by 256, top 186) directly, with
// all duties, enables and compare values cleared
`default_nettype none

module four_channel_pwm_timer_unit #(
    parameter int NUM_CHANNELS = 4,
    parameter int CLOCK_HZ     = 48000000
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration
    input  wire logic                          cfg_wr_en,
    input  wire logic [fcpwm_pkg::FREQ_W-1:0]  cfg_wr_data,
    // command channel
    input  wire logic                          s_valid,
    output wire logic                          s_ready,
    input  wire logic [2:0]                    s_opcode,
    input  wire logic [2:0]                    s_channel,
    input  wire logic [15:0]                   s_duty,
    // result channel
    output wire logic                          m_valid,
    input  wire logic                          m_ready,
    output wire logic [3:0]                    m_pwm_levels,
    output wire logic [7:0]                    m_read_duty,
    output wire logic                          m_accepted
);

    localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int DW     = fcpwm_pkg::DUTY_W;
    localparam int TW     = fcpwm_pkg::TOP_W;
    localparam int SW     = fcpwm_pkg::SEL_W;
    localparam int PW     = fcpwm_pkg::PCNT_W;
    localparam logic [3:0]    NUM_CH_VAL  = 4'(NUM_CHANNELS);
    localparam logic [CH_W-1:0] LAST_CH   = CH_W'(NUM_CHANNELS - 1);
    localparam logic [TW-1:0] TOP_RESET   = 8'd186;
    localparam logic [SW-1:0] SEL_RESET   = 3'd6;

    // input register
    logic                  in_valid_reg;
    logic [2:0]            op_reg;
    logic [2:0]            ch_reg;
    logic [15:0]           duty_reg;

    // timer state
    logic [DW-1:0]         stored_duty_reg [NUM_CHANNELS];
    logic [DW-1:0]         compare_reg     [NUM_CHANNELS];
    logic [DW-1:0]         compare_next    [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] enable_mask_reg;
    logic [TW-1:0]         counter_top_reg;
    logic [SW-1:0]         prescale_sel_reg;
    logic [PW-1:0]         prescale_count_reg;
    logic [TW-1:0]         wave_count_reg;

    // compare rebuild after a frequency change
    logic                  sweep_active_reg;
    logic [CH_W-1:0]       sweep_idx_reg;

    // result register
    logic                  m_valid_reg;
    logic [3:0]            pwm_reg;
    logic [7:0]            read_duty_reg;
    logic                  accepted_reg;

    fcpwm_pkg::freq_status_t solver_status;

    logic                  busy;
    logic                  advance;
    logic                  ch_valid;
    logic [CH_W-1:0]       ch_idx;
    logic [CH_W-1:0]       duty_idx;
    logic [DW-1:0]         duty_clamped;
    logic [DW-1:0]         duty_src;
    logic [15:0]           scale_prod;
    logic [16:0]           scale_sum;
    logic [DW-1:0]         scaled;
    logic [3:0]            levels;
    logic [PW:0]           pcount_inc;
    logic [PW:0]           divisor;
    logic                  is_cmd;

    fcpwm_freq_solver #(
        .CLOCK_HZ (CLOCK_HZ)
    ) u_solver (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cfg_wr_en),
        .freq    (cfg_wr_data),
        .status  (solver_status)
    );

    assign busy    = solver_status.busy | solver_status.done | sweep_active_reg;
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !busy && (!in_valid_reg || advance);

    assign ch_valid = {1'b0, ch_reg} < NUM_CH_VAL;
    assign ch_idx   = ch_reg[CH_W-1:0];
    assign is_cmd   = (op_reg == fcpwm_pkg::OP_SET) || (op_reg == fcpwm_pkg::OP_ENABLE)
                   || (op_reg == fcpwm_pkg::OP_DISABLE) || (op_reg == fcpwm_pkg::OP_READ);

    assign duty_clamped = (duty_reg > 16'd255) ? 8'd255 : duty_reg[7:0];

    // one shared scaler and its duty read port, the rebuild sweep borrows them
    assign duty_idx = sweep_active_reg ? sweep_idx_reg : ch_idx;
    assign duty_src = (!sweep_active_reg && op_reg == fcpwm_pkg::OP_SET)
                    ? duty_clamped : stored_duty_reg[duty_idx];

    // duty * top / 255, exact for products below 65536
    assign scale_prod = 16'(duty_src) * 16'(counter_top_reg);
    assign scale_sum  = 17'(scale_prod) + 17'(scale_prod >> 8) + 17'd1;
    assign scaled     = scale_sum[15:8];

    always_comb begin
        for (int i = 0; i < NUM_CHANNELS; i++) compare_next[i] = compare_reg[i];
        if (ch_valid) begin
            case (op_reg)
                fcpwm_pkg::OP_SET,
                fcpwm_pkg::OP_ENABLE:  compare_next[ch_idx] = scaled;
                fcpwm_pkg::OP_DISABLE: compare_next[ch_idx] = '0;
                default: ;
            endcase
        end
    end

    // levels use the compare values as this command leaves them; a tick
    // leaves them untouched and sees the count before it advances
    for (genvar g = 0; g < 4; g++) begin : g_level
        if (g < NUM_CHANNELS) begin : g_on
            assign levels[g] = wave_count_reg < compare_next[g];
        end else begin : g_off
            assign levels[g] = 1'b0;
        end
    end

    assign pcount_inc = {1'b0, prescale_count_reg} + 1'b1;
    assign divisor    = (PW + 1)'(1) << fcpwm_pkg::prescale_shift(prescale_sel_reg);

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
                op_reg       <= s_opcode;
                ch_reg       <= s_channel;
                duty_reg     <= s_duty;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
        end
    end

    // timer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                stored_duty_reg[i] <= '0;
                compare_reg[i]     <= '0;
            end
            enable_mask_reg    <= '0;
            counter_top_reg    <= TOP_RESET;
            prescale_sel_reg   <= SEL_RESET;
            prescale_count_reg <= '0;
            wave_count_reg     <= '0;
            sweep_active_reg   <= 1'b0;
            sweep_idx_reg      <= '0;
        end else if (cfg_wr_en) begin
            // restart the timer and drop every compare until rebuilt
            for (int i = 0; i < NUM_CHANNELS; i++) compare_reg[i] <= '0;
            prescale_count_reg <= '0;
            wave_count_reg     <= '0;
            sweep_active_reg   <= 1'b0;
        end else if (solver_status.done) begin
            prescale_sel_reg <= solver_status.sel;
            counter_top_reg  <= solver_status.top;
            sweep_active_reg <= 1'b1;
            sweep_idx_reg    <= '0;
        end else if (sweep_active_reg) begin
            compare_reg[sweep_idx_reg] <= enable_mask_reg[sweep_idx_reg] ? scaled : '0;
            sweep_idx_reg <= sweep_idx_reg + 1'b1;
            if (sweep_idx_reg == LAST_CH) sweep_active_reg <= 1'b0;
        end else if (advance) begin
            for (int i = 0; i < NUM_CHANNELS; i++) compare_reg[i] <= compare_next[i];
            if (op_reg == fcpwm_pkg::OP_TICK) begin
                if (pcount_inc >= divisor) begin
                    prescale_count_reg <= '0;
                    wave_count_reg     <= (wave_count_reg >= counter_top_reg)
                                        ? '0 : wave_count_reg + 1'b1;
                end else begin
                    prescale_count_reg <= pcount_inc[PW-1:0];
                end
            end else if (ch_valid) begin
                case (op_reg)
                    fcpwm_pkg::OP_SET:     stored_duty_reg[ch_idx] <= duty_clamped;
                    fcpwm_pkg::OP_ENABLE:  enable_mask_reg[ch_idx] <= 1'b1;
                    fcpwm_pkg::OP_DISABLE: enable_mask_reg[ch_idx] <= 1'b0;
                    default: ;
                endcase
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                m_valid_reg   <= 1'b1;
                pwm_reg       <= levels;
                read_duty_reg <= (op_reg == fcpwm_pkg::OP_READ && ch_valid)
                               ? stored_duty_reg[ch_idx] : '0;
                accepted_reg  <= (op_reg == fcpwm_pkg::OP_TICK) || (is_cmd && ch_valid);
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pwm_levels = pwm_reg;
    assign m_read_duty  = read_duty_reg;
    assign m_accepted   = accepted_reg;

    // no command enters while the period is being solved or rebuilt
    assert property (@(posedge aclk) disable iff (!aresetn) busy |-> !s_ready)
        else $error("command taken during frequency update");

    // a frequency write restarts the waveform
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> (wave_count_reg == '0) && (prescale_count_reg == '0))
        else $error("timer not restarted by frequency write");

    // the waveform count never passes the period top
    assert property (@(posedge aclk) disable iff (!aresetn)
        wave_count_reg <= counter_top_reg)
        else $error("wave count beyond top");

    // the prescaler count stays below the selected ratio
    assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, prescale_count_reg} < divisor))
        else $error("prescaler count beyond ratio");

    // scaled compare values never exceed the period top
    for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_chk
        assert property (@(posedge aclk) disable iff (!aresetn)
            compare_reg[g] <= counter_top_reg)
            else $error("compare value beyond top");
    end

endmodule

`default_nettype wire
